### hw/rtl/lbbcd_pkg.sv
// Package of the tile cache directory: request/result types, codes and widths.
// Used by the top, lbbcd_ctrl and lbbcd_rsp; depends on nothing.
`default_nettype none
package lbbcd_pkg;

   localparam int DEFAULT_ENTRIES     = 16;
   localparam int DEFAULT_HANDLE_BITS = 8;

   localparam int BUDGET_BITS    = 38;
   localparam int TOTAL_BITS     = 39;
   localparam int BYTES_BITS     = 34;
   localparam int REQ_TDATA_BITS = 112;
   localparam int RSP_TDATA_BITS = 40;
   // level + rect + width + height + byte cost; handle and rank are added per build
   localparam int ENTRY_FIXED_BITS = 4 + 64 + 16 + 16 + 34;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] ST_HIT   = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FREED = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  level;
      logic [63:0] rect;
      logic [15:0] tile_width;
      logic [15:0] tile_height;
      logic [7:0]  buffer_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_handle;
      logic [15:0] out_width;
      logic [15:0] out_height;
      logic        last;
   } result_type;

endpackage
`default_nettype wire

### hw/rtl/lru_byte_budget_cache_directory_top.sv
// Top level of the LRU tile cache directory with a byte budget.
// Depends on lbbcd_pkg, lbbcd_mem, lbbcd_ctrl and lbbcd_rsp.
//
// Usage:
//  - req_* carries one request: mode in req_tuser (lookup, insert, clear),
//    key, tile size and buffer handle in req_tdata.
//  - rsp_* returns the results of each request in order: a lookup gives one
//    hit or miss; an insert gives one freed handle per eviction, or done; a
//    clear gives one freed handle per entry, least recent first, or done.
//    rsp_tlast marks the final result of a request.
//  - csr_* writes the byte budget; write it only while no request is open.
// Sequencing: one request at a time. Every walk reads the entry memory one entry a
//    cycle, one pass covering all entries. Lookup: a search pass, and on a hit an
//    aging pass and a write of the hit. Insert: an aging pass that also finds a free
//    slot, a write and a budget check, plus a search pass and a removal per eviction.
//    Clear: a search pass and a removal per valid entry.
// Reset empties the directory and sets the budget to zero at once; no sweep.
// A stalled rsp_tready holds the current result in the output register; the
//    sequencer keeps one more result pending and then waits.
`default_nettype none
module lru_byte_budget_cache_directory_top #(
   parameter int ENTRIES     = lbbcd_pkg::DEFAULT_ENTRIES,
   parameter int HANDLE_BITS = lbbcd_pkg::DEFAULT_HANDLE_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // level, rect_left, rect_top, rect_right, rect_bottom, tile_width,
   // tile_height, buffer_handle, then zero pad
   input  wire logic [lbbcd_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  wire logic [1:0]  req_tuser,  // mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [lbbcd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata, // out_handle, out_width, out_height
   output logic [1:0]       rsp_tuser,  // status
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [lbbcd_pkg::BUDGET_BITS-1:0] csr_data  // byte_budget
);

   localparam int IW = $clog2(ENTRIES);
   localparam int EW = lbbcd_pkg::ENTRY_FIXED_BITS + HANDLE_BITS + IW;

   lbbcd_pkg::req_type    req;
   lbbcd_pkg::result_type res;
   logic                  res_valid;
   logic                  res_ready;
   logic                  mem_wr_en;
   logic [IW-1:0]         mem_wr_addr;
   logic [EW-1:0]         mem_wr_data;
   logic [IW-1:0]         mem_rd_addr;
   logic [EW-1:0]         mem_rd_data;

   // unpack the request fields, lowest bits first
   always_comb begin
      req.mode          = req_tuser;
      req.level         = req_tdata[3:0];
      req.rect          = req_tdata[67:4];
      req.tile_width    = req_tdata[83:68];
      req.tile_height   = req_tdata[99:84];
      req.buffer_handle = req_tdata[107:100];
   end

   // the budget register takes a write in any cycle
   assign csr_ready = 1'b1;

   lbbcd_mem #(
      .DEPTH     (ENTRIES),
      .ADDR_BITS (IW),
      .DATA_BITS (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lbbcd_ctrl #(
      .ENTRIES     (ENTRIES),
      .HANDLE_BITS (HANDLE_BITS),
      .IW          (IW),
      .EW          (EW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   lbbcd_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (res_valid),
      .in_ready   (res_ready),
      .in_res     (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### hw/rtl/lbbcd_mem.sv
// Entry memory of the directory: one write port, one read port, registered read.
// Generic; depends on nothing.
`default_nettype none
module lbbcd_mem #(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int DATA_BITS = 142
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/lbbcd_rsp.sv
// Result output register: decouples the sequencer from the result stream.
// Depends on lbbcd_pkg.
`default_nettype none
module lbbcd_rsp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire lbbcd_pkg::result_type  in_res,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [lbbcd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata, // out_handle, out_width, out_height
   output logic [1:0]                  rsp_tuser,          // status
   output logic                        rsp_tlast
);

   logic                  valid_ff;
   logic                  valid_in;
   lbbcd_pkg::result_type res_ff;

   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= in_res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.out_height, res_ff.out_width, res_ff.out_handle};
   assign rsp_tuser  = res_ff.status;
   assign rsp_tlast  = res_ff.last;

endmodule
`default_nettype wire

### hw/rtl/lbbcd_ctrl.sv
// Sequencer of the directory: scans the entry memory, updates recency ranks,
// inserts and evicts entries and forms results. Depends on lbbcd_pkg.
`default_nettype none
module lbbcd_ctrl #(
   parameter int ENTRIES     = lbbcd_pkg::DEFAULT_ENTRIES,
   parameter int HANDLE_BITS = lbbcd_pkg::DEFAULT_HANDLE_BITS,
   parameter int IW          = $clog2(ENTRIES),
   parameter int EW          = lbbcd_pkg::ENTRY_FIXED_BITS + HANDLE_BITS + $clog2(ENTRIES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lbbcd_pkg::req_type    req,
   input  wire logic                  csr_valid,
   input  wire logic [lbbcd_pkg::BUDGET_BITS-1:0] csr_data,
   output logic                       mem_wr_en,
   output logic      [IW-1:0]         mem_wr_addr,
   output logic      [EW-1:0]         mem_wr_data,
   output logic      [IW-1:0]         mem_rd_addr,
   input  wire logic [EW-1:0]         mem_rd_data,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output lbbcd_pkg::result_type      res
);

   localparam int CW = $clog2(ENTRIES + 1);

   typedef struct packed {
      logic [3:0]                       level;
      logic [63:0]                      rect;
      logic [15:0]                      w;
      logic [15:0]                      h;
      logic [HANDLE_BITS-1:0]           handle;
      logic [lbbcd_pkg::BYTES_BITS-1:0] bytes;
      logic [IW-1:0]                    rank;
   } entry_type;

   typedef enum logic [10:0] {
      IDLE    = 11'b000_0000_0001,
      LK_SCAN = 11'b000_0000_0010,
      LK_UPD  = 11'b000_0000_0100,
      LK_WR   = 11'b000_0000_1000,
      INS_INC = 11'b000_0001_0000,
      INS_WR  = 11'b000_0010_0000,
      INS_CHK = 11'b000_0100_0000,
      EV_SCAN = 11'b000_1000_0000,
      EVICT   = 11'b001_0000_0000,
      CLR_CHK = 11'b010_0000_0000,
      FIN     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [lbbcd_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic [lbbcd_pkg::BUDGET_BITS-1:0] budget_ff, budget_in;
   lbbcd_pkg::req_type req_ff, req_in;
   logic [lbbcd_pkg::BYTES_BITS-1:0] bytes_ff, bytes_in;
   logic pre_ev_ff, pre_ev_in;
   logic best_found_ff, best_found_in;
   entry_type best_ff, best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic ev_found_ff, ev_found_in;
   logic [IW-1:0] ev_idx_ff, ev_idx_in;
   logic [HANDLE_BITS-1:0] ev_handle_ff, ev_handle_in;
   logic [lbbcd_pkg::BYTES_BITS-1:0] ev_bytes_ff, ev_bytes_in;
   logic slot_found_ff, slot_found_in;
   logic [IW-1:0] slot_idx_ff, slot_idx_in;
   logic pend_valid_ff, pend_valid_in;
   lbbcd_pkg::result_type pend_ff, pend_in;

   entry_type rd_ent;
   entry_type new_ent;
   logic [31:0] prod;
   logic proc_valid;
   logic [IW-1:0] proc_idx;
   logic scan_end;
   logic [15:0] ev_handle16;
   logic [15:0] best_handle16;

   assign rd_ent        = entry_type'(mem_rd_data);
   assign prod          = req.tile_width * req.tile_height;
   assign proc_valid    = cnt_ff != '0;
   assign proc_idx      = IW'(cnt_ff - CW'(1));
   assign scan_end      = cnt_ff == CW'(ENTRIES);
   assign mem_rd_addr   = (cnt_ff < CW'(ENTRIES)) ? cnt_ff[IW-1:0] : '0;
   assign ev_handle16   = 16'(ev_handle_ff);
   assign best_handle16 = 16'(best_ff.handle);
   assign req_ready     = state_ff == IDLE;

   always_comb begin
      new_ent.level  = req_ff.level;
      new_ent.rect   = req_ff.rect;
      new_ent.w      = req_ff.tile_width;
      new_ent.h      = req_ff.tile_height;
      new_ent.handle = HANDLE_BITS'(16'(req_ff.buffer_handle));
      new_ent.bytes  = bytes_ff;
      new_ent.rank   = '0;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      budget_in     = budget_ff;
      req_in        = req_ff;
      bytes_in      = bytes_ff;
      pre_ev_in     = pre_ev_ff;
      best_found_in = best_found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      ev_found_in   = ev_found_ff;
      ev_idx_in     = ev_idx_ff;
      ev_handle_in  = ev_handle_ff;
      ev_bytes_in   = ev_bytes_ff;
      slot_found_in = slot_found_ff;
      slot_idx_in   = slot_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = proc_idx;
      mem_wr_data   = rd_ent;
      res_valid     = 1'b0;
      res           = pend_ff;

      if (csr_valid) begin
         budget_in = csr_data;
      end

      unique case (state_ff)
         IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               req_in        = req;
               bytes_in      = {prod, 2'b00};
               pre_ev_in     = 1'b0;
               best_found_in = 1'b0;
               ev_found_in   = 1'b0;
               slot_found_in = 1'b0;
               pend_valid_in = 1'b0;
               case (req.mode)
                  lbbcd_pkg::MODE_LOOKUP: state_in = LK_SCAN;
                  lbbcd_pkg::MODE_INSERT: begin
                     if (count_ff == CW'(ENTRIES)) begin
                        pre_ev_in = 1'b1;
                        state_in  = EV_SCAN;
                     end else begin
                        state_in = INS_INC;
                     end
                  end
                  lbbcd_pkg::MODE_CLEAR: state_in = CLR_CHK;
                  default: state_in = FIN;
               endcase
            end
         end
         LK_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (proc_valid && valid_ff[proc_idx] && rd_ent.level == req_ff.level &&
                rd_ent.rect == req_ff.rect && (!best_found_ff || rd_ent.rank < best_ff.rank)) begin
               best_found_in = 1'b1;
               best_in       = rd_ent;
               best_idx_in   = proc_idx;
            end
            if (scan_end) begin
               cnt_in   = '0;
               state_in = LK_UPD;
            end
         end
         LK_UPD: begin
            if (!best_found_ff) begin
               pend_in       = '{status: lbbcd_pkg::ST_MISS, out_handle: '0,
                                 out_width: '0, out_height: '0, last: 1'b0};
               pend_valid_in = 1'b1;
               state_in      = FIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
               // age every entry that was more recent than the hit
               if (proc_valid && valid_ff[proc_idx] && rd_ent.rank < best_ff.rank) begin
                  mem_wr_en        = 1'b1;
                  mem_wr_data      = rd_ent;
                  mem_wr_data[IW-1:0] = rd_ent.rank + IW'(1);
               end
               if (scan_end) begin
                  cnt_in   = '0;
                  state_in = LK_WR;
               end
            end
         end
         LK_WR: begin
            mem_wr_en           = 1'b1;
            mem_wr_addr         = best_idx_ff;
            mem_wr_data         = best_ff;
            mem_wr_data[IW-1:0] = '0;
            pend_in       = '{status: lbbcd_pkg::ST_HIT, out_handle: best_handle16[7:0],
                              out_width: best_ff.w, out_height: best_ff.h, last: 1'b0};
            pend_valid_in = 1'b1;
            state_in      = FIN;
         end
         INS_INC: begin
            cnt_in = cnt_ff + CW'(1);
            if (proc_valid) begin
               if (valid_ff[proc_idx]) begin
                  mem_wr_en           = 1'b1;
                  mem_wr_data         = rd_ent;
                  mem_wr_data[IW-1:0] = rd_ent.rank + IW'(1);
               end else if (!slot_found_ff) begin
                  slot_found_in = 1'b1;
                  slot_idx_in   = proc_idx;
               end
            end
            if (scan_end) begin
               cnt_in   = '0;
               state_in = INS_WR;
            end
         end
         INS_WR: begin
            mem_wr_en              = 1'b1;
            mem_wr_addr            = slot_idx_ff;
            mem_wr_data            = new_ent;
            valid_in[slot_idx_ff]  = 1'b1;
            count_in               = count_ff + CW'(1);
            total_in               = total_ff + lbbcd_pkg::TOTAL_BITS'(bytes_ff);
            state_in               = INS_CHK;
         end
         INS_CHK: begin
            cnt_in      = '0;
            ev_found_in = 1'b0;
            if (total_ff > {1'b0, budget_ff} && count_ff != '0) begin
               state_in = EV_SCAN;
            end else begin
               state_in = FIN;
            end
         end
         EV_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            // ranks form a permutation, so the oldest holds rank count-1
            if (proc_valid && valid_ff[proc_idx] &&
                CW'(rd_ent.rank) == count_ff - CW'(1)) begin
               ev_found_in  = 1'b1;
               ev_idx_in    = proc_idx;
               ev_handle_in = rd_ent.handle;
               ev_bytes_in  = rd_ent.bytes;
            end
            if (scan_end) begin
               cnt_in   = '0;
               state_in = EVICT;
            end
         end
         EVICT: begin
            res_valid = pend_valid_ff;
            if (!pend_valid_ff || res_ready) begin
               pend_in       = '{status: lbbcd_pkg::ST_FREED, out_handle: ev_handle16[7:0],
                                 out_width: '0, out_height: '0, last: 1'b0};
               pend_valid_in = 1'b1;
               valid_in[ev_idx_ff] = 1'b0;
               count_in      = count_ff - CW'(1);
               total_in      = total_ff - lbbcd_pkg::TOTAL_BITS'(ev_bytes_ff);
               ev_found_in   = 1'b0;
               case (req_ff.mode)
                  lbbcd_pkg::MODE_INSERT: begin
                     if (pre_ev_ff) begin
                        pre_ev_in     = 1'b0;
                        slot_found_in = 1'b0;
                        state_in      = INS_INC;
                     end else begin
                        state_in = INS_CHK;
                     end
                  end
                  lbbcd_pkg::MODE_CLEAR: state_in = CLR_CHK;
                  default: state_in = FIN;
               endcase
            end
         end
         CLR_CHK: begin
            cnt_in      = '0;
            ev_found_in = 1'b0;
            if (count_ff != '0) begin
               state_in = EV_SCAN;
            end else begin
               total_in = '0;
               state_in = FIN;
            end
         end
         FIN: begin
            res_valid = 1'b1;
            if (pend_valid_ff) begin
               res      = pend_ff;
               res.last = 1'b1;
            end else begin
               res = '{status: lbbcd_pkg::ST_DONE, out_handle: '0,
                       out_width: '0, out_height: '0, last: 1'b1};
            end
            if (res_ready) begin
               pend_valid_in = 1'b0;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         budget_ff     <= '0;
         pre_ev_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         ev_found_ff   <= 1'b0;
         slot_found_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         budget_ff     <= budget_in;
         pre_ev_ff     <= pre_ev_in;
         best_found_ff <= best_found_in;
         ev_found_ff   <= ev_found_in;
         slot_found_ff <= slot_found_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      bytes_ff     <= bytes_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      ev_idx_ff    <= ev_idx_in;
      ev_handle_ff <= ev_handle_in;
      ev_bytes_ff  <= ev_bytes_in;
      slot_idx_ff  <= slot_idx_in;
      pend_ff      <= pend_in;
   end

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff))
      else $error("entry count disagrees with valid bits");

   a_empty_has_no_bytes: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> total_ff == '0)
      else $error("empty table still holds bytes");

   a_evict_has_victim: assert property (@(posedge clock) disable iff (reset)
      state_ff == EVICT |-> ev_found_ff)
      else $error("eviction without a least recent entry");

   a_insert_has_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == INS_WR |-> slot_found_ff && !valid_ff[slot_idx_ff])
      else $error("insert without a free slot");

endmodule
`default_nettype wire
